// File: hdl/quaternion_point_rotation_core_macros.svh
// ----------------------------------------------------------------------------
// quaternion point rotation core assertion macros
// shared concurrent assertion forms, clocked on clk_i, quiet in reset
// ----------------------------------------------------------------------------
`ifndef QUATERNION_POINT_ROTATION_CORE_MACROS_SVH
`define QUATERNION_POINT_ROTATION_CORE_MACROS_SVH

// same-cycle implication
`define QPR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("qpr assertion failed");

// next-cycle implication
`define QPR_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("qpr assertion failed");

`endif

// File: hdl/qpr_pkg.sv
// ----------------------------------------------------------------------------
// qpr_pkg
// shared widths and stage payload types of the quaternion rotation pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package qpr_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned InW      = 16;
  localparam int unsigned CompW    = 17;
  localparam int unsigned RootW    = 16;
  localparam int unsigned RemW     = 20;
  localparam int unsigned NumComp  = 4;
  localparam int unsigned NumCoord = 3;
  localparam int unsigned SqrtIter = 16;

  typedef struct packed {
    logic [NumComp-1:0][DataW-1:0] t;
    logic [NumComp-1:0][CompW-1:0] cj;
    logic                          neg;
  } side_t;

  typedef struct packed {
    logic [DataW-1:0] rad;
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
  } sqrt_t;

endpackage

`default_nettype wire

// File: hdl/qpr_front.sv
// ----------------------------------------------------------------------------
// qpr_front
// two stages: conjugate, squares and q*v products, then sums and radicand
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qpr_front #(
  parameter int unsigned FRAC_BITS = 12
) (
  input  wire logic                                               clk_i,
  input  wire logic [1:0]                                         en_i,
  input  wire logic [qpr_pkg::NumComp-1:0][qpr_pkg::InW-1:0]      quat_i,
  input  wire logic [qpr_pkg::NumCoord-1:0][qpr_pkg::InW-1:0]     vec_i,
  output qpr_pkg::side_t                                          side_o,
  output logic [qpr_pkg::DataW-1:0]                               rad_o
);

  localparam logic [qpr_pkg::DataW-1:0] FracMask =
    qpr_pkg::DataW'((64'd1 << FRAC_BITS) - 64'd1);

  logic signed [qpr_pkg::DataW-1:0] qe [qpr_pkg::NumComp];
  logic signed [qpr_pkg::DataW-1:0] ve [qpr_pkg::NumCoord];
  logic signed [qpr_pkg::DataW-1:0] ce [qpr_pkg::NumComp];

  logic [qpr_pkg::NumComp-1:0][qpr_pkg::CompW-1:0]                      cj_d, cj_q;
  logic [qpr_pkg::NumComp-1:0][qpr_pkg::DataW-1:0]                      sq_d, sq_q;
  logic [qpr_pkg::NumComp-1:0][qpr_pkg::NumCoord-1:0][qpr_pkg::DataW-1:0] pm_d, pm_q;

  logic [qpr_pkg::DataW-1:0] sum;
  qpr_pkg::side_t            side_d;
  logic [qpr_pkg::DataW-1:0] rad_d;

  // stage a
  always_comb begin
    for (int i = 0; i < qpr_pkg::NumComp; i++) begin
      qe[i] = qpr_pkg::DataW'($signed(quat_i[i]));
    end
    for (int j = 0; j < qpr_pkg::NumCoord; j++) begin
      ve[j] = qpr_pkg::DataW'($signed(vec_i[j]));
    end
    for (int i = 0; i < qpr_pkg::NumComp; i++) begin
      if (i == qpr_pkg::NumComp - 1) begin
        ce[i] = qe[i];
      end else begin
        ce[i] = -qe[i];
      end
      cj_d[i] = ce[i][qpr_pkg::CompW-1:0];
      sq_d[i] = ce[i] * ce[i];
      for (int j = 0; j < qpr_pkg::NumCoord; j++) begin
        pm_d[i][j] = (qe[i] * ve[j]) >>> FRAC_BITS;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      cj_q <= cj_d;
      sq_q <= sq_d;
      pm_q <= pm_d;
    end
  end

  // stage b
  always_comb begin
    sum          = sq_q[0] + sq_q[1] + sq_q[2] + sq_q[3];
    rad_d        = sum & ~FracMask;
    side_d.neg   = sum[qpr_pkg::DataW-1];
    side_d.cj    = cj_q;
    side_d.t[3]  = qpr_pkg::DataW'(0) - pm_q[0][0] - pm_q[1][1] - pm_q[2][2];
    side_d.t[0]  = pm_q[3][0] + pm_q[1][2] - pm_q[2][1];
    side_d.t[1]  = pm_q[3][1] + pm_q[2][0] - pm_q[0][2];
    side_d.t[2]  = pm_q[3][2] + pm_q[0][1] - pm_q[1][0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      side_o <= side_d;
      rad_o  <= rad_d;
    end
  end

endmodule

`default_nettype wire

// File: hdl/qpr_sqrt_stage.sv
// ----------------------------------------------------------------------------
// qpr_sqrt_stage
// one root bit of the restoring square root, registered
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qpr_sqrt_stage #(
  parameter int unsigned IDX = 0
) (
  input  wire logic            clk_i,
  input  wire logic            en_i,
  input  wire qpr_pkg::sqrt_t  d_i,
  input  wire qpr_pkg::side_t  side_i,
  output qpr_pkg::sqrt_t       d_o,
  output qpr_pkg::side_t       side_o
);

  logic [qpr_pkg::RemW-1:0] sh;
  logic [qpr_pkg::RemW-1:0] trial;
  qpr_pkg::sqrt_t           d_d;

  always_comb begin
    sh    = {d_i.rem[qpr_pkg::RemW-3:0], d_i.rad[2*IDX+1 -: 2]};
    trial = qpr_pkg::RemW'({d_i.root, 2'b01});
    d_d   = d_i;
    if (sh >= trial) begin
      d_d.rem  = sh - trial;
      d_d.root = {d_i.root[qpr_pkg::RootW-2:0], 1'b1};
    end else begin
      d_d.rem  = sh;
      d_d.root = {d_i.root[qpr_pkg::RootW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_o    <= d_d;
      side_o <= side_i;
    end
  end

endmodule

`default_nettype wire

// File: hdl/qpr_div_stage.sv
// ----------------------------------------------------------------------------
// qpr_div_stage
// one quotient bit of four restoring dividers sharing the magnitude
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qpr_div_stage #(
  parameter int unsigned FRAC_BITS = 12,
  parameter int unsigned BIT       = 0
) (
  input  wire logic                                                        clk_i,
  input  wire logic                                                        en_i,
  input  wire qpr_pkg::side_t                                              side_i,
  input  wire logic [qpr_pkg::RootW-1:0]                                   mag_i,
  input  wire logic [qpr_pkg::NumComp-1:0][qpr_pkg::RootW+FRAC_BITS-1:0]   num_i,
  input  wire logic [qpr_pkg::NumComp-1:0][qpr_pkg::RootW-1:0]             rem_i,
  input  wire logic [qpr_pkg::NumComp-1:0][qpr_pkg::RootW+FRAC_BITS-1:0]   quo_i,
  output qpr_pkg::side_t                                                   side_o,
  output logic [qpr_pkg::RootW-1:0]                                        mag_o,
  output logic [qpr_pkg::NumComp-1:0][qpr_pkg::RootW+FRAC_BITS-1:0]        num_o,
  output logic [qpr_pkg::NumComp-1:0][qpr_pkg::RootW-1:0]                  rem_o,
  output logic [qpr_pkg::NumComp-1:0][qpr_pkg::RootW+FRAC_BITS-1:0]        quo_o
);

  logic [qpr_pkg::RootW:0]                                        sh [qpr_pkg::NumComp];
  logic [qpr_pkg::NumComp-1:0][qpr_pkg::RootW-1:0]                rem_d;
  logic [qpr_pkg::NumComp-1:0][qpr_pkg::RootW+FRAC_BITS-1:0]      quo_d;

  always_comb begin
    quo_d = quo_i;
    for (int i = 0; i < qpr_pkg::NumComp; i++) begin
      sh[i] = {rem_i[i], num_i[i][BIT]};
      if (sh[i] >= {1'b0, mag_i}) begin
        rem_d[i]      = qpr_pkg::RootW'(sh[i] - {1'b0, mag_i});
        quo_d[i][BIT] = 1'b1;
      end else begin
        rem_d[i] = sh[i][qpr_pkg::RootW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_o <= side_i;
      mag_o  <= mag_i;
      num_o  <= num_i;
      rem_o  <= rem_d;
      quo_o  <= quo_d;
    end
  end

endmodule

`default_nettype wire

// File: hdl/qpr_back.sv
// ----------------------------------------------------------------------------
// qpr_back
// two stages: signed conjugate selection with t*conj products, then sums
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qpr_back #(
  parameter int unsigned FRAC_BITS = 12
) (
  input  wire logic                                                      clk_i,
  input  wire logic [1:0]                                                en_i,
  input  wire qpr_pkg::side_t                                            side_i,
  input  wire logic [qpr_pkg::RootW-1:0]                                 mag_i,
  input  wire logic [qpr_pkg::NumComp-1:0][qpr_pkg::RootW+FRAC_BITS-1:0] quo_i,
  output logic [qpr_pkg::NumCoord-1:0][qpr_pkg::DataW-1:0]               rot_o
);

  logic                              byp;
  logic signed [qpr_pkg::DataW-1:0]  te [qpr_pkg::NumComp];
  logic signed [qpr_pkg::DataW-1:0]  ce [qpr_pkg::NumComp];

  logic [qpr_pkg::NumCoord-1:0][qpr_pkg::NumComp-1:0][qpr_pkg::DataW-1:0] mr_d, mr_q;
  logic [qpr_pkg::NumCoord-1:0][qpr_pkg::DataW-1:0]                       rot_d;

  function automatic logic [qpr_pkg::DataW-1:0] fmul(
    input logic signed [qpr_pkg::DataW-1:0] a,
    input logic signed [qpr_pkg::DataW-1:0] b
  );
    logic signed [qpr_pkg::DataW-1:0] p;
    p    = a * b;
    fmul = p >>> FRAC_BITS;
  endfunction

  // stage x
  always_comb begin
    byp = side_i.neg || (mag_i == '0);
    for (int i = 0; i < qpr_pkg::NumComp; i++) begin
      te[i] = side_i.t[i];
      if (byp) begin
        ce[i] = qpr_pkg::DataW'($signed(side_i.cj[i]));
      end else if (side_i.cj[i][qpr_pkg::CompW-1]) begin
        ce[i] = -qpr_pkg::DataW'(quo_i[i]);
      end else begin
        ce[i] = qpr_pkg::DataW'(quo_i[i]);
      end
    end
    mr_d[0][0] = fmul(te[0], ce[3]);
    mr_d[0][1] = fmul(te[3], ce[0]);
    mr_d[0][2] = fmul(te[1], ce[2]);
    mr_d[0][3] = fmul(te[2], ce[1]);
    mr_d[1][0] = fmul(te[1], ce[3]);
    mr_d[1][1] = fmul(te[3], ce[1]);
    mr_d[1][2] = fmul(te[2], ce[0]);
    mr_d[1][3] = fmul(te[0], ce[2]);
    mr_d[2][0] = fmul(te[2], ce[3]);
    mr_d[2][1] = fmul(te[3], ce[2]);
    mr_d[2][2] = fmul(te[0], ce[1]);
    mr_d[2][3] = fmul(te[1], ce[0]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      mr_q <= mr_d;
    end
  end

  // stage y
  always_comb begin
    for (int k = 0; k < qpr_pkg::NumCoord; k++) begin
      rot_d[k] = mr_q[k][0] + mr_q[k][1] + mr_q[k][2] - mr_q[k][3];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      rot_o <= rot_d;
    end
  end

endmodule

`default_nettype wire

// File: hdl/quaternion_point_rotation_core.sv
// ----------------------------------------------------------------------------
// quaternion_point_rotation_core
// rotates a point by a quaternion through its normalized conjugate
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o   quat_x/y/z/w_i, vec_x/y/z_i
//   out      output     out_valid_o / out_stall_i rot_x/y/z_o
//
// one word per cycle sustained while out_stall_i is low
// stages: 2 front, 16 square root bits, 16 + FRAC_BITS quotient bits, 2 back
// each stage holds a valid bit; a stage loads when it is empty or moving on
// reset clears only the valid bits
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "quaternion_point_rotation_core_macros.svh"

module quaternion_point_rotation_core #(
  parameter int unsigned FRAC_BITS = 12
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [15:0] quat_x_i,
  input  wire logic signed [15:0] quat_y_i,
  input  wire logic signed [15:0] quat_z_i,
  input  wire logic signed [15:0] quat_w_i,
  input  wire logic signed [15:0] vec_x_i,
  input  wire logic signed [15:0] vec_y_i,
  input  wire logic signed [15:0] vec_z_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [31:0]      rot_x_o,
  output logic signed [31:0]      rot_y_o,
  output logic signed [31:0]      rot_z_o
);

  localparam int unsigned NW  = qpr_pkg::RootW + FRAC_BITS;
  localparam int unsigned SQ0 = 2;
  localparam int unsigned DV0 = SQ0 + qpr_pkg::SqrtIter;
  localparam int unsigned BK0 = DV0 + NW;
  localparam int unsigned NS  = BK0 + 2;

  logic [NS-1:0] v_q, v_d;
  logic [NS:0]   rdy;

  logic [qpr_pkg::NumComp-1:0][qpr_pkg::InW-1:0]  quat_a;
  logic [qpr_pkg::NumCoord-1:0][qpr_pkg::InW-1:0] vec_a;

  qpr_pkg::side_t            side_sq [qpr_pkg::SqrtIter+1];
  qpr_pkg::sqrt_t            sq      [qpr_pkg::SqrtIter+1];
  logic [qpr_pkg::DataW-1:0] rad_f;

  qpr_pkg::side_t                                        side_dv [NW+1];
  logic [qpr_pkg::RootW-1:0]                             mag_a   [NW+1];
  logic [qpr_pkg::NumComp-1:0][NW-1:0]                   num_a   [NW+1];
  logic [qpr_pkg::NumComp-1:0][qpr_pkg::RootW-1:0]       rem_a   [NW+1];
  logic [qpr_pkg::NumComp-1:0][NW-1:0]                   quo_a   [NW+1];
  logic [qpr_pkg::NumComp-1:0][qpr_pkg::CompW-1:0]       abs_c;

  logic [qpr_pkg::NumCoord-1:0][qpr_pkg::DataW-1:0]      rot;

  // flow control
  always_comb begin
    rdy[NS] = !out_stall_i;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
    v_d = {v_q[NS-2:0], in_valid_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_d[k];
        end
      end
    end
  end

  assign in_stall_o  = !rdy[0];
  assign out_valid_o = v_q[NS-1];

  assign quat_a = {quat_w_i, quat_z_i, quat_y_i, quat_x_i};
  assign vec_a  = {vec_z_i, vec_y_i, vec_x_i};

  qpr_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk_i  (clk_i),
    .en_i   (rdy[1:0]),
    .quat_i (quat_a),
    .vec_i  (vec_a),
    .side_o (side_sq[0]),
    .rad_o  (rad_f)
  );

  assign sq[0] = '{rad: rad_f, rem: '0, root: '0};

  for (genvar k = 0; k < qpr_pkg::SqrtIter; k++) begin : g_sqrt
    qpr_sqrt_stage #(
      .IDX (qpr_pkg::SqrtIter - 1 - k)
    ) u_sqrt (
      .clk_i  (clk_i),
      .en_i   (rdy[SQ0+k]),
      .d_i    (sq[k]),
      .side_i (side_sq[k]),
      .d_o    (sq[k+1]),
      .side_o (side_sq[k+1])
    );
  end

  always_comb begin
    for (int i = 0; i < qpr_pkg::NumComp; i++) begin
      if (side_sq[qpr_pkg::SqrtIter].cj[i][qpr_pkg::CompW-1]) begin
        abs_c[i] = -side_sq[qpr_pkg::SqrtIter].cj[i];
      end else begin
        abs_c[i] = side_sq[qpr_pkg::SqrtIter].cj[i];
      end
      num_a[0][i] = {abs_c[i][qpr_pkg::RootW-1:0], {FRAC_BITS{1'b0}}};
    end
  end

  assign side_dv[0] = side_sq[qpr_pkg::SqrtIter];
  assign mag_a[0]   = sq[qpr_pkg::SqrtIter].root;
  assign rem_a[0]   = '0;
  assign quo_a[0]   = '0;

  for (genvar j = 0; j < NW; j++) begin : g_div
    qpr_div_stage #(
      .FRAC_BITS (FRAC_BITS),
      .BIT       (NW - 1 - j)
    ) u_div (
      .clk_i  (clk_i),
      .en_i   (rdy[DV0+j]),
      .side_i (side_dv[j]),
      .mag_i  (mag_a[j]),
      .num_i  (num_a[j]),
      .rem_i  (rem_a[j]),
      .quo_i  (quo_a[j]),
      .side_o (side_dv[j+1]),
      .mag_o  (mag_a[j+1]),
      .num_o  (num_a[j+1]),
      .rem_o  (rem_a[j+1]),
      .quo_o  (quo_a[j+1])
    );
  end

  qpr_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i  (clk_i),
    .en_i   (rdy[BK0+1:BK0]),
    .side_i (side_dv[NW]),
    .mag_i  (mag_a[NW]),
    .quo_i  (quo_a[NW]),
    .rot_o  (rot)
  );

  assign rot_x_o = $signed(rot[0]);
  assign rot_y_o = $signed(rot[1]);
  assign rot_z_o = $signed(rot[2]);

  `QPR_ASSERT(a_stall_only_full, in_stall_o |-> (&v_q))
  `QPR_ASSERT(a_free_out_free_in, !out_stall_i |-> !in_stall_o)
  `QPR_ASSERT_NEXT(a_word_enters, in_valid_i && !in_stall_o, v_q[0])
  `QPR_ASSERT_NEXT(a_drain, out_valid_o && !out_stall_i && !v_q[NS-2], !out_valid_o)

endmodule

`default_nettype wire
